### hw/rtl/indexed_ordered_list_defines.svh
// Assertion macros for the indexed ordered list.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH
`ifndef SYNTHESIS
`define IOL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_ordered_list: immediate check failed");
`define IOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_ordered_list: next-cycle check failed");
`else
`define IOL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IOL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/iol_pkg.sv
// Shared types, codes and sizes for the indexed ordered list.
// Depends on nothing; used by iol_cell and indexed_ordered_list.
package iol_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int LEN_W    = 7;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 16;

    localparam logic [2:0] REQ_READ     = 3'd0;
    localparam logic [2:0] REQ_INS_HEAD = 3'd1;
    localparam logic [2:0] REQ_INS_TAIL = 3'd2;
    localparam logic [2:0] REQ_INS_AT   = 3'd3;
    localparam logic [2:0] REQ_DELETE   = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic        [2:0]       req_type;
        logic signed [POS_W-1:0] position;
        logic signed [VAL_W-1:0] value_in;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_out;
        logic        [1:0]       status;
        logic        [LEN_W-1:0] length;
    } t_res;

    // per-cell control: load new value, take from lower neighbour,
    // take from upper neighbour, drive the read bus
    typedef struct packed {
        logic load;
        logic up;
        logic down;
        logic sel;
    } t_cell_ctl;

endpackage

### hw/rtl/iol_cell.sv
// One storage cell of the list chain: holds one entry, shifts with neighbours.
// Depends on iol_pkg.
module iol_cell (
    input  logic                                i_clk,
    input  iol_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [iol_pkg::VAL_W-1:0]    i_value_in,
    input  logic signed [iol_pkg::VAL_W-1:0]    i_prev,
    input  logic signed [iol_pkg::VAL_W-1:0]    i_next,
    output logic signed [iol_pkg::VAL_W-1:0]    o_entry,
    output logic        [iol_pkg::VAL_W-1:0]    o_rd
);

    logic signed [iol_pkg::VAL_W-1:0] r_entry;
    logic signed [iol_pkg::VAL_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_value_in;
        end else if (i_ctl.up) begin
            n_entry = i_prev;
        end else if (i_ctl.down) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    // contribute to the wired-OR read bus only when selected
    assign o_rd    = r_entry & {iol_pkg::VAL_W{i_ctl.sel}};

endmodule

### hw/rtl/indexed_ordered_list.sv
// Top level of the indexed ordered list: request decode, cell chain, result register.
// Depends on iol_pkg, iol_cell and indexed_ordered_list_defines.svh.
//
//  channel  | direction | payload          | handshake
//  ---------+-----------+------------------+------------------------------
//  request  | in        | i_in_req (t_req) | i_in_valid  / o_in_stall
//  result   | out       | o_out_res (t_res)| o_out_valid / i_out_stall
//
// Cycles: one request per cycle while the result side is not stalled; its result is
//   registered and offered on the cycle after acceptance. The rate is set by the cell
//   chain, which shifts every entry above the slot by one place together, and by the
//   read bus, an OR over all cells feeding the result register.
// Reset: clears the entry count and the result valid; cell contents are left
//   undefined, as no position at or above the count is ever read.
// Stalls: a request is stalled only while a result is held and the consumer
//   stalls; a taken result frees the register in the same cycle.
`include "indexed_ordered_list_defines.svh"

module indexed_ordered_list (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  iol_pkg::t_req   i_in_req,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output iol_pkg::t_res   o_out_res,
    input  logic            i_out_stall
);

    localparam int CAP = iol_pkg::CAPACITY;
    localparam int CW  = iol_pkg::CNT_W;
    localparam int VW  = iol_pkg::VAL_W;
    localparam int PW  = iol_pkg::POS_W;

    // entry count and result register
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_out_valid;
    iol_pkg::t_res   r_res;
    iol_pkg::t_res   n_res;

    logic            in_acc;

    // decoded request
    logic            pos_neg;
    logic [PW-1:0]   pos_mag;
    logic [PW-1:0]   cnt_ext;
    logic            in_range;
    logic            ins_req;
    logic            do_ins;
    logic            do_del;
    logic [CW-1:0]   ins_pos;
    logic [CW-1:0]   del_pos;

    // cell chain
    iol_pkg::t_cell_ctl        cell_ctl [CAP];
    logic signed [VW-1:0]      cell_entry [CAP];
    logic        [VW-1:0]      cell_rd [CAP];
    logic        [VW-1:0]      rd_bus;

    // hold the request while a result waits and the consumer stalls
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    assign pos_neg  = i_in_req.position[PW-1];
    assign pos_mag  = {1'b0, i_in_req.position[PW-2:0]};
    assign cnt_ext  = PW'(r_count);
    assign in_range = ~pos_neg && (pos_mag < cnt_ext);

    // OR the selected cell onto the read bus
    always_comb begin
        rd_bus = '0;
        for (int k = 0; k < CAP; k++) begin
            rd_bus = rd_bus | cell_rd[k];
        end
    end

    // decode the request and form the result
    always_comb begin
        ins_req         = 1'b0;
        do_ins          = 1'b0;
        do_del          = 1'b0;
        ins_pos         = '0;
        del_pos         = pos_mag[CW-1:0];
        n_res.value_out = '0;
        n_res.status    = iol_pkg::ST_DONE;
        case (i_in_req.req_type)
            iol_pkg::REQ_READ: begin
                if (in_range) begin
                    n_res.value_out = rd_bus;
                end else begin
                    n_res.value_out = '1;
                    n_res.status    = iol_pkg::ST_INVALID;
                end
            end
            iol_pkg::REQ_INS_HEAD: begin
                ins_req = 1'b1;
            end
            iol_pkg::REQ_INS_TAIL: begin
                ins_req = 1'b1;
                ins_pos = r_count;
            end
            iol_pkg::REQ_INS_AT: begin
                // clamp a negative position to the head; drop a position beyond the length
                if (pos_neg) begin
                    ins_req = 1'b1;
                end else if (pos_mag > cnt_ext) begin
                    n_res.status = iol_pkg::ST_INVALID;
                end else begin
                    ins_req = 1'b1;
                    ins_pos = pos_mag[CW-1:0];
                end
            end
            iol_pkg::REQ_DELETE: begin
                if (in_range) begin
                    do_del = 1'b1;
                end else begin
                    n_res.status = iol_pkg::ST_INVALID;
                end
            end
            default: begin
                n_res.status = iol_pkg::ST_INVALID;
            end
        endcase
        if (ins_req) begin
            if (r_count >= CW'(CAP)) begin
                n_res.status = iol_pkg::ST_FULL;
            end else begin
                do_ins = 1'b1;
            end
        end
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_del) begin
            n_count = r_count - CW'(1);
        end
        n_res.length = iol_pkg::LEN_W'(n_count);
    end

    // cell chain: insert shifts cells above the slot up, delete shifts the slot and cells above it down
    for (genvar k = 0; k < CAP; k++) begin : g_cell
        logic signed [VW-1:0] prev_entry;
        logic signed [VW-1:0] next_entry;

        if (k == 0) begin : g_first
            assign prev_entry = i_in_req.value_in;
        end else begin : g_mid
            assign prev_entry = cell_entry[k-1];
        end
        if (k == CAP - 1) begin : g_last
            assign next_entry = cell_entry[k];
        end else begin : g_inner
            assign next_entry = cell_entry[k+1];
        end

        assign cell_ctl[k].load = in_acc & do_ins & (CW'(k) == ins_pos);
        assign cell_ctl[k].up   = in_acc & do_ins & (CW'(k) >  ins_pos);
        assign cell_ctl[k].down = in_acc & do_del & (CW'(k) >= del_pos);
        assign cell_ctl[k].sel  = (pos_mag == PW'(k));

        iol_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl[k]),
            .i_value_in (i_in_req.value_in),
            .i_prev     (prev_entry),
            .i_next     (next_entry),
            .o_entry    (cell_entry[k]),
            .o_rd       (cell_rd[k])
        );
    end

    // update the count on every accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_acc) begin
            r_count <= n_count;
        end
    end

    // result register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_res;

    // the count never passes the capacity
    `IOL_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAP))
    // a completed insert grows the list by exactly one
    `IOL_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, in_acc && do_ins, r_count == $past(r_count) + CW'(1))
    // a full drop is reported only with the list at capacity
    `IOL_ASSERT_IMPLY(a_full_len, i_clk, i_rst_n, r_out_valid && (r_res.status == iol_pkg::ST_FULL), r_res.length == iol_pkg::LEN_W'(CAP))
    // a result that waits under stall holds still
    `IOL_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid && $stable(r_res))

endmodule
